### hw/rtl/vfb_pkg.sv
package vfb_pkg;

   localparam int EXP_BITS = 20;
   localparam int DIV_BITS = 16;
   // Each exponent bit takes a partial product stage and a summing stage.
   localparam int STEPS = 2 * EXP_BITS;

   localparam logic [16:0] F_ONE  = 17'h10000;
   localparam logic [16:0] F_ZERO = 17'h00000;

   localparam logic [2:0] CSR_ENABLE  = 3'd0;
   localparam logic [2:0] CSR_MODE    = 3'd1;
   localparam logic [2:0] CSR_START   = 3'd2;
   localparam logic [2:0] CSR_END     = 3'd3;
   localparam logic [2:0] CSR_DENSITY = 3'd4;
   localparam logic [2:0] CSR_COLOR   = 3'd5;

   localparam logic [1:0] MODE_LINEAR = 2'd0;
   localparam logic [1:0] MODE_EXP    = 2'd1;
   localparam logic [1:0] MODE_EXP2   = 2'd2;
   // The spare mode code behaves as fog off.
   localparam logic [1:0] MODE_OFF    = 2'd3;

   localparam logic [1:0] KIND_CONST = 2'd0;
   localparam logic [1:0] KIND_LIN   = 2'd1;
   localparam logic [1:0] KIND_EXP   = 2'd2;

   localparam logic [62:0] ACC_ONE = 63'h4000_0000_0000_0000;

   typedef struct packed {
      logic        fog_enable;
      logic [1:0]  fog_mode;
      logic [31:0] fog_start;
      logic [31:0] fog_end;
      logic [23:0] fog_density;
      logic [31:0] fog_color;
   } cfg_type;

   typedef struct packed {
      logic [31:0] vc;
      logic [1:0]  kind;
      logic [16:0] fconst;
      logic [19:0] pbits;
      logic [31:0] rem;
      logic [31:0] den;
      logic [15:0] quot;
      logic [62:0] acc;
      logic [63:0] pp_lo;
      logic [63:0] pp_m1;
      logic [63:0] pp_m2;
      logic [63:0] pp_hi;
   } pipe_type;

   // exp(-2^(k-16)) in Q62, built by repeated truncated squaring.
   function automatic logic [61:0] fac_q62(input int k);
      logic [127:0] f;
      logic [127:0] prod;
      f = (128'd1 << 62) - (128'd1 << 46) + (128'd1 << 29) - 128'd2731;
      for (int i = 0; i < k; i++) begin
         prod = f * f;
         f = prod >> 62;
      end
      return f[61:0];
   endfunction

endpackage

### hw/rtl/vfb_req_if.sv
interface vfb_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] depth;
   logic [31:0] vertex_color;

   modport source (output valid, output depth, output vertex_color, input ready);
   modport sink (input valid, input depth, input vertex_color, output ready);
endinterface

### hw/rtl/vfb_rsp_if.sv
interface vfb_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] fogged_color;
   logic [16:0] fog_factor;

   modport source (output valid, output fogged_color, output fog_factor, input ready);
   modport sink (input valid, input fogged_color, input fog_factor, output ready);
endinterface

### hw/rtl/vfb_csr.sv
module vfb_csr import vfb_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        write_enable,
   input  logic [2:0]  index,
   input  logic [31:0] write_data,
   output cfg_type     cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (write_enable) begin
         unique case (index)
            CSR_ENABLE:  cfg_in.fog_enable  = write_data[0];
            CSR_MODE:    cfg_in.fog_mode    = write_data[1:0];
            CSR_START:   cfg_in.fog_start   = write_data;
            CSR_END:     cfg_in.fog_end     = write_data;
            CSR_DENSITY: cfg_in.fog_density = write_data[23:0];
            CSR_COLOR:   cfg_in.fog_color   = write_data;
            default:     cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.fog_enable  <= 1'b0;
         cfg_ff.fog_mode    <= MODE_LINEAR;
         cfg_ff.fog_start   <= 32'd0;
         cfg_ff.fog_end     <= 32'd65536;
         cfg_ff.fog_density <= 24'd65536;
         cfg_ff.fog_color   <= 32'd0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

### hw/rtl/vfb_front.sv
module vfb_front import vfb_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        advance,
   input  cfg_type     cfg,
   input  logic        up_valid,
   input  logic [31:0] depth,
   input  logic [31:0] vertex_color,
   output logic        dn_valid,
   output pipe_type    dn_data
);

   // Stage 1: linear numerator and denominator, density times |z| in halves.
   logic               s1_valid_ff;
   logic [31:0]        s1_vc_ff;
   logic               s1_zpos_ff;
   logic signed [32:0] s1_num_ff;
   logic signed [32:0] s1_den_ff;
   logic [39:0]        s1_pp_lo_ff;
   logic [39:0]        s1_pp_hi_ff;
   logic signed [32:0] s1_num_in;
   logic signed [32:0] s1_den_in;
   logic [31:0]        zabs;

   always_comb begin
      zabs = depth[31] ? (32'd0 - depth) : depth;
      s1_num_in = $signed({cfg.fog_end[31], cfg.fog_end}) - $signed({depth[31], depth});
      s1_den_in = $signed({cfg.fog_end[31], cfg.fog_end})
                  - $signed({cfg.fog_start[31], cfg.fog_start});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_vc_ff    <= vertex_color;
         s1_zpos_ff  <= !depth[31] && (depth != 32'd0);
         s1_num_ff   <= s1_num_in;
         s1_den_ff   <= s1_den_in;
         s1_pp_lo_ff <= 40'(cfg.fog_density) * 40'(zabs[15:0]);
         s1_pp_hi_ff <= 40'(cfg.fog_density) * 40'(zabs[31:16]);
      end
   end

   // Stage 2: scaled depth and the linear special cases.
   logic               s2_valid_ff;
   logic [31:0]        s2_vc_ff;
   logic               s2_zpos_ff;
   logic [39:0]        s2_q_ff;
   logic [1:0]         s2_lin_kind_ff;
   logic [16:0]        s2_lin_const_ff;
   logic [31:0]        s2_rem_ff;
   logic [31:0]        s2_den_ff;
   logic [55:0]        prod;
   logic signed [32:0] n;
   logic signed [32:0] d;
   logic [1:0]         s2_lin_kind_in;
   logic [16:0]        s2_lin_const_in;

   always_comb begin
      prod = 56'(s1_pp_lo_ff) + (56'(s1_pp_hi_ff) << 16);
      n = s1_num_ff;
      d = s1_den_ff;
      if (d < 0) begin
         n = -n;
         d = -d;
      end
      s2_lin_kind_in  = KIND_LIN;
      s2_lin_const_in = F_ONE;
      priority if (d == 0) begin
         s2_lin_kind_in = KIND_CONST;
      end else if (n <= 0) begin
         s2_lin_kind_in  = KIND_CONST;
         s2_lin_const_in = F_ZERO;
      end else if (n >= d) begin
         s2_lin_kind_in = KIND_CONST;
      end else begin
         s2_lin_kind_in = KIND_LIN;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (advance) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s2_vc_ff        <= s1_vc_ff;
         s2_zpos_ff      <= s1_zpos_ff;
         s2_q_ff         <= prod[55:16];
         s2_lin_kind_ff  <= s2_lin_kind_in;
         s2_lin_const_ff <= s2_lin_const_in;
         s2_rem_ff       <= n[31:0];
         s2_den_ff       <= d[31:0];
      end
   end

   // Stage 3: exponent selection per mode.
   logic        s3_valid_ff;
   pipe_type    s3_data_ff;
   pipe_type    s3_data_in;
   logic [35:0] qsq;

   always_comb begin
      qsq = 36'(s2_q_ff[17:0]) * 36'(s2_q_ff[17:0]);
      s3_data_in        = '0;
      s3_data_in.vc     = s2_vc_ff;
      s3_data_in.rem    = s2_rem_ff;
      s3_data_in.den    = s2_den_ff;
      s3_data_in.acc    = ACC_ONE;
      s3_data_in.kind   = KIND_CONST;
      s3_data_in.fconst = F_ONE;
      if (cfg.fog_enable) begin
         unique case (cfg.fog_mode)
            MODE_LINEAR: begin
               s3_data_in.kind   = s2_lin_kind_ff;
               s3_data_in.fconst = s2_lin_const_ff;
            end
            MODE_EXP: begin
               if (s2_zpos_ff) begin
                  if (s2_q_ff >= (40'd12 << 16)) begin
                     s3_data_in.fconst = F_ZERO;
                  end else begin
                     s3_data_in.kind  = KIND_EXP;
                     s3_data_in.pbits = s2_q_ff[19:0];
                  end
               end
            end
            MODE_EXP2: begin
               if (s2_q_ff >= (40'd4 << 16) || qsq[35:16] >= (20'd12 << 16)) begin
                  s3_data_in.fconst = F_ZERO;
               end else begin
                  s3_data_in.kind  = KIND_EXP;
                  s3_data_in.pbits = qsq[35:16];
               end
            end
            default: begin
               s3_data_in.fconst = F_ONE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (advance) begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s3_data_ff <= s3_data_in;
      end
   end

   assign dn_valid = s3_valid_ff;
   assign dn_data  = s3_data_ff;

endmodule

### hw/rtl/vfb_step.sv
module vfb_step import vfb_pkg::*; #(
   parameter int IDX = 0
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     advance,
   input  logic     up_valid,
   input  pipe_type up_data,
   output logic     dn_valid,
   output pipe_type dn_data
);

   localparam int          K   = IDX / 2;
   localparam logic [61:0] FAC = fac_q62(K);

   logic        valid_ff;
   pipe_type    data_ff;
   pipe_type    data_in;
   logic [127:0] full;
   logic [32:0]  shifted;

   always_comb begin
      data_in = up_data;
      full = {up_data.pp_hi, 64'd0} + {32'd0, up_data.pp_m1, 32'd0}
             + {32'd0, up_data.pp_m2, 32'd0} + {64'd0, up_data.pp_lo};
      shifted = {up_data.rem, 1'b0};
      if (IDX % 2 == 0) begin
         // Split the Q62 product into four 32-bit partial products.
         data_in.pp_lo = 64'(up_data.acc[31:0]) * 64'(FAC[31:0]);
         data_in.pp_m1 = 64'(up_data.acc[62:32]) * 64'(FAC[31:0]);
         data_in.pp_m2 = 64'(up_data.acc[31:0]) * 64'(FAC[61:32]);
         data_in.pp_hi = 64'(up_data.acc[62:32]) * 64'(FAC[61:32]);
      end else if (up_data.pbits[K]) begin
         data_in.acc = full[124:62];
      end
      // Linear divide: one restoring step per stage below DIV_BITS.
      if (IDX < DIV_BITS) begin
         if (shifted >= {1'b0, up_data.den}) begin
            data_in.rem  = 32'(shifted - {1'b0, up_data.den});
            data_in.quot = {up_data.quot[14:0], 1'b1};
         end else begin
            data_in.rem  = shifted[31:0];
            data_in.quot = {up_data.quot[14:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         data_ff <= data_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_data  = data_ff;

endmodule

### hw/rtl/vfb_blend.sv
module vfb_blend import vfb_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        advance,
   input  logic [31:0] fog_color,
   input  logic        up_valid,
   input  pipe_type    up_data,
   output logic        out_valid,
   output logic [31:0] out_color,
   output logic [16:0] out_factor
);

   logic        valid_ff;
   logic [31:0] color_ff;
   logic [16:0] factor_ff;
   logic [31:0] color_in;
   logic [16:0] factor_in;
   logic [62:0] rounded;
   logic [24:0] mix;

   always_comb begin
      rounded = up_data.acc + (63'd1 << 45);
      unique case (up_data.kind)
         KIND_LIN: factor_in = {1'b0, up_data.quot};
         KIND_EXP: factor_in = rounded[62:46];
         default:  factor_in = up_data.fconst;
      endcase
      color_in = '0;
      mix = '0;
      for (int ch = 0; ch < 4; ch++) begin
         mix = 25'(factor_in) * 25'(up_data.vc[8*ch +: 8])
               + 25'(F_ONE - factor_in) * 25'(fog_color[8*ch +: 8]);
         color_in[8*ch +: 8] = mix[23:16];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         color_ff  <= color_in;
         factor_ff <= factor_in;
      end
   end

   assign out_valid  = valid_ff;
   assign out_color  = color_ff;
   assign out_factor = factor_ff;

endmodule

### hw/rtl/vertex_fog_blend.sv
// Channel  Direction  Payload
// req      in         depth (signed Q16.16), vertex_color (RGBA8888)
// rsp      out        fogged_color (RGBA8888), fog_factor (Q1.16)
// csr      in         write enable, 3-bit register index, 32-bit data
//
// One vertex per cycle while the output is not stalled; three front stages, forty
// stages for the exponent product chain (one Q62 multiply per exponent bit,
// as partial products then a sum), with the linear divider in the first
// sixteen of those, and one blend stage that is the output register.
// Synchronous reset clears the valid bits and loads the configuration defaults.
// When a result waits untaken the whole pipeline holds; req.ready is
// rsp.ready or an empty output register.
module vertex_fog_blend import vfb_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   vfb_req_if.sink     req,
   vfb_rsp_if.source   rsp,
   input  logic        csr_write_enable,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_write_data
);

   cfg_type        cfg;
   logic           advance;
   logic [STEPS:0] stage_valid;
   pipe_type       stage_data [0:STEPS];

   assign advance   = rsp.ready || !rsp.valid;
   assign req.ready = advance;

   vfb_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .write_enable (csr_write_enable),
      .index        (csr_index),
      .write_data   (csr_write_data),
      .cfg          (cfg)
   );

   vfb_front u_front (
      .clock        (clock),
      .reset        (reset),
      .advance      (advance),
      .cfg          (cfg),
      .up_valid     (req.valid),
      .depth        (req.depth),
      .vertex_color (req.vertex_color),
      .dn_valid     (stage_valid[0]),
      .dn_data      (stage_data[0])
   );

   for (genvar i = 0; i < STEPS; i++) begin : g_step
      vfb_step #(.IDX(i)) u_step (
         .clock    (clock),
         .reset    (reset),
         .advance  (advance),
         .up_valid (stage_valid[i]),
         .up_data  (stage_data[i]),
         .dn_valid (stage_valid[i+1]),
         .dn_data  (stage_data[i+1])
      );
   end

   vfb_blend u_blend (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .fog_color  (cfg.fog_color),
      .up_valid   (stage_valid[STEPS]),
      .up_data    (stage_data[STEPS]),
      .out_valid  (rsp.valid),
      .out_color  (rsp.fogged_color),
      .out_factor (rsp.fog_factor)
   );

   a_factor_range: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> rsp.fog_factor <= F_ONE)
      else $error("fog factor above one");

   a_disabled_factor: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !cfg.fog_enable |-> rsp.fog_factor == F_ONE)
      else $error("fog disabled but factor is not one");

   a_stall_blocks_input: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |-> !req.ready)
      else $error("input taken while output stalled");

   a_reset_empties: assert property (@(posedge clock)
      reset |=> !rsp.valid)
      else $error("result valid after reset");

endmodule

### test/fog_checker.sv
`timescale 1ns / 100ps
module fog_checker import vfb_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   vfb_req_if          req,
   vfb_rsp_if          rsp,
   input  logic        csr_write_enable,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_write_data,
   output int          fail_count,
   output int          pending_count
);

   typedef struct packed {
      logic [31:0] color;
      logic [16:0] factor;
   } fog_result_type;

   logic        enable_ff;
   logic [1:0]  mode_ff;
   logic [31:0] start_ff;
   logic [31:0] end_ff;
   logic [23:0] density_ff;
   logic [31:0] fogcolor_ff;

   fog_result_type expected_results[$];

   // Truncated Q62 product: (a * b) >> 62.
   function automatic logic [63:0] q62_mul(input logic [63:0] a, input logic [63:0] b);
      logic [127:0] prod;
      prod = a * b;
      return prod[125:62];
   endfunction

   function automatic logic [16:0] neg_exp(input logic [63:0] p);
      logic [63:0] acc;
      logic [63:0] fac;
      acc = 64'd1 << 62;
      fac = (64'd1 << 62) - (64'd1 << 46) + (64'd1 << 29) - 64'd2731;
      if (p >= (64'd12 << 16)) return 17'd0;
      for (int k = 0; k < 20; k++) begin
         if (p[k]) acc = q62_mul(acc, fac);
         fac = q62_mul(fac, fac);
      end
      acc = (acc + (64'd1 << 45)) >> 46;
      return acc[16:0];
   endfunction

   function automatic logic [16:0] linear_ramp(input logic signed [63:0] z);
      logic signed [63:0] num;
      logic signed [63:0] den;
      logic [63:0]        quo;
      num = $signed(end_ff) - z;
      den = $signed(end_ff) - $signed(start_ff);
      if (den == 0) return F_ONE;
      if (den < 0) begin
         num = -num;
         den = -den;
      end
      if (num <= 0) return F_ZERO;
      if (num >= den) return F_ONE;
      quo = (64'(num) << 16) / 64'(den);
      return quo[16:0];
   endfunction

   function automatic fog_result_type shade_vertex(input logic [31:0] depth,
                                                   input logic [31:0] vcolor);
      fog_result_type     r;
      logic signed [63:0] z;
      logic [63:0]        zabs;
      logic [63:0]        q;
      logic [63:0]        f;
      logic [63:0]        ch;
      z = $signed(depth);
      zabs = (z < 0) ? 64'(-z) : 64'(z);
      f = 64'(F_ONE);
      if (!enable_ff || mode_ff == MODE_OFF) begin
         r.color = vcolor;
         r.factor = F_ONE;
         return r;
      end
      if (mode_ff == MODE_LINEAR) begin
         f = 64'(linear_ramp(z));
      end else if (mode_ff == MODE_EXP) begin
         if (z > 0) f = 64'(neg_exp((64'(density_ff) * zabs) >> 16));
      end else begin
         q = (64'(density_ff) * zabs) >> 16;
         if (q >= (64'd4 << 16)) f = 0;
         else f = 64'(neg_exp((q * q) >> 16));
      end
      for (int sh = 0; sh < 32; sh += 8) begin
         ch = (f * 64'((vcolor >> sh) & 8'hFF) +
               (64'd65536 - f) * 64'((fogcolor_ff >> sh) & 8'hFF)) >> 16;
         r.color[sh +: 8] = ch[7:0];
      end
      r.factor = f[16:0];
      return r;
   endfunction

   always @(posedge clock) begin
      fog_result_type want;
      int             errs;
      errs = 0;
      if (reset) begin
         enable_ff <= 1'b0;
         mode_ff <= MODE_LINEAR;
         start_ff <= 32'd0;
         end_ff <= 32'd65536;
         density_ff <= 24'd65536;
         fogcolor_ff <= 32'd0;
         fail_count <= 0;
         pending_count <= 0;
         expected_results.delete();
      end else begin
         // Predict with the settings in force before this edge's write.
         if (req.valid && req.ready)
            expected_results.push_back(shade_vertex(req.depth, req.vertex_color));
         if (rsp.valid && rsp.ready) begin
            if (expected_results.size() == 0) begin
               $error("unexpected transfer: color %h factor %h",
                      rsp.fogged_color, rsp.fog_factor);
               errs = errs + 1;
            end else begin
               want = expected_results.pop_front();
               if (rsp.fogged_color !== want.color) begin
                  $error("fogged_color: expected %h actual %h",
                         want.color, rsp.fogged_color);
                  errs = errs + 1;
               end
               if (rsp.fog_factor !== want.factor) begin
                  $error("fog_factor: expected %h actual %h",
                         want.factor, rsp.fog_factor);
                  errs = errs + 1;
               end
            end
         end
         if (csr_write_enable) begin
            unique case (csr_index)
               CSR_ENABLE: enable_ff <= csr_write_data[0];
               CSR_MODE: mode_ff <= csr_write_data[1:0];
               CSR_START: start_ff <= csr_write_data;
               CSR_END: end_ff <= csr_write_data;
               CSR_DENSITY: density_ff <= csr_write_data[23:0];
               CSR_COLOR: fogcolor_ff <= csr_write_data;
               default: ;
            endcase
         end
         fail_count <= fail_count + errs;
         pending_count <= expected_results.size();
      end
   end

endmodule

### test/tb.sv
`timescale 1ns / 100ps
module tb import vfb_pkg::*;;

   // Register index with nothing behind it; writes there are ignored.
   localparam logic [2:0] CSR_SPARE = 3'd6;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_write_enable = 1'b0;
   logic [2:0]  csr_index = '0;
   logic [31:0] csr_write_data = '0;
   int          fail_count;
   int          pending_count;
   bit          rsp_calm = 1'b0;
   bit          rsp_hold = 1'b0;
   bit          req_calm = 1'b0;
   bit          bulk_started = 1'b0;

   vfb_req_if req ();
   vfb_rsp_if rsp ();

   vertex_fog_blend dut (
      .clock(clock), .reset(reset), .req(req.sink), .rsp(rsp.source),
      .csr_write_enable(csr_write_enable), .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   fog_checker checker_inst (
      .clock(clock), .reset(reset), .req(req), .rsp(rsp),
      .csr_write_enable(csr_write_enable), .csr_index(csr_index),
      .csr_write_data(csr_write_data), .fail_count(fail_count),
      .pending_count(pending_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Result side: random stalls, a calm stretch, and one long hold-off.
   always @(posedge clock) begin
      if (reset) rsp.ready <= 1'b0;
      else if (rsp_hold) rsp.ready <= 1'b0;
      else rsp.ready <= rsp_calm || ($urandom_range(99) >= 10);
   end

   // The hold-off starts while a long burst is being offered, so the block fills.
   initial begin
      wait (bulk_started);
      repeat (30) @(posedge clock);
      rsp_hold = 1'b1;
      repeat (150) @(posedge clock);
      rsp_hold = 1'b0;
      repeat (200) @(posedge clock);
      rsp_calm = 1'b1;
      repeat (300) @(posedge clock);
      rsp_calm = 1'b0;
   end

   task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= data;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      @(posedge clock);
   endtask

   // Offers one vertex and holds it until the transfer happens.
   task automatic send_vertex(input logic [31:0] depth, input logic [31:0] vcolor);
      while (!req_calm && $urandom_range(99) < 10) begin
         req.valid <= 1'b0;
         @(posedge clock);
      end
      req.valid <= 1'b1;
      req.depth <= depth;
      req.vertex_color <= vcolor;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
   endtask

   task automatic drain_pipe();
      req.valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (50) @(posedge clock);
   endtask

   function automatic logic [31:0] random_depth();
      unique case ($urandom_range(3))
         0: return $urandom();
         1: return 32'($signed($urandom_range(16 << 16)) - (8 << 16));
         2: return 32'($urandom_range(4 << 16));
         default: return 32'(-$signed($urandom_range(2 << 16)));
      endcase
   endfunction

   task automatic set_phase(input logic en, input logic [1:0] md, input logic [31:0] st,
                            input logic [31:0] en_z, input logic [23:0] dn,
                            input logic [31:0] fc);
      write_reg(CSR_ENABLE, {31'd0, en});
      write_reg(CSR_MODE, {30'd0, md});
      write_reg(CSR_START, st);
      write_reg(CSR_END, en_z);
      write_reg(CSR_DENSITY, {8'd0, dn});
      write_reg(CSR_COLOR, fc);
   endtask

   initial begin
      logic [31:0] dvals[8];
      logic [1:0]  md;
      req.valid <= 1'b0;
      req.depth <= '0;
      req.vertex_color <= '0;
      dvals = '{32'h8000_0000, 32'h7FFF_FFFF, 32'd0, 32'hFFFF_FFFF, 32'd1,
                32'h0001_0000, 32'h0000_8000, 32'hFFFF_0000};
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // Fog off with reset settings, then each mode at its extremes.
      for (int i = 0; i < 4; i++)
         send_vertex(dvals[3'(i)], 32'hFF00_FF00 ^ (i * 32'h1111_1111));
      drain_pipe();
      for (int m = 0; m < 4; m++) begin
         set_phase(1'b1, 2'(m), 32'd0, 32'h0002_0000, 24'hFFFFFF, 32'hFFFF_FFFF);
         for (int i = 0; i < 5; i++) send_vertex(dvals[3'((i + m) % 8)], 32'h0000_0000);
         drain_pipe();
      end
      // Equal start and end, and the widest range.
      set_phase(1'b1, MODE_LINEAR, 32'h0003_0000, 32'h0003_0000, 24'd0, 32'h80FF_0001);
      send_vertex(32'h0001_0000, 32'h1234_5678);
      drain_pipe();
      write_reg(CSR_START, 32'h8000_0000);
      write_reg(CSR_END, 32'h7FFF_FFFF);
      send_vertex(32'd0, 32'hFFFF_FFFF);
      send_vertex(32'h7FFF_FFFF, 32'hFFFF_FFFF);
      drain_pipe();
      write_reg(CSR_SPARE, 32'hFFFF_FFFF);
      for (int ph = 0; ph < 12; ph++) begin
         md = (ph % 6 == 5) ? MODE_OFF : 2'(ph % 3);
         set_phase(($urandom_range(7) != 0), md,
                   (ph == 0) ? 32'h8000_0000 : 32'($signed($urandom_range(8 << 16)) - (4 << 16)),
                   (ph == 0) ? 32'h7FFF_FFFF : 32'($urandom_range(8 << 16)),
                   (ph == 1) ? 24'd0 : (ph == 2) ? 24'hFFFFFF : 24'($urandom_range(4 << 16)),
                   $urandom());
         req_calm = (ph == 4);
         if (ph == 1) bulk_started = 1'b1;
         for (int i = 0; i < 100; i++) send_vertex(random_depth(), $urandom());
         req_calm = 1'b0;
         drain_pipe();
      end
      if (fail_count == 0) $display("tb OK");
      else $display("tb NOT OK");
      $finish;
   end

   initial begin
      #5ms;
      $display("tb NOT OK");
      $finish;
   end

endmodule

### filelist.f
hw/rtl/vfb_pkg.sv
hw/rtl/vfb_req_if.sv
hw/rtl/vfb_rsp_if.sv
hw/rtl/vfb_csr.sv
hw/rtl/vfb_front.sv
hw/rtl/vfb_step.sv
hw/rtl/vfb_blend.sv
hw/rtl/vertex_fog_blend.sv
test/fog_checker.sv
test/tb.sv
